// ===== design/rss_pkg.sv =====
// shared types, constants and helper functions for the receiver scan scheduler
// used by rss_lane, rss_merge and receiver_scan_scheduler_core
package rss_pkg;

  localparam int NUM_RECEIVERS = 4;
  localparam int MAX_TARGETS   = 16;
  localparam int TIME_WIDTH    = 32;

  localparam int COUNT_W  = 5;
  localparam int CURSOR_W = 4;
  localparam int DUR_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [CURSOR_W-1:0]   cursor_t;
  typedef logic [DUR_W-1:0]      dur_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_MASK   = 2'd0,
    REG_TARGET_COUNTS = 2'd1,
    REG_DWELL_TIMES   = 2'd2,
    REG_HANG_TIMES    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic    emit;
    cursor_t idx;
  } lane_result_t;

  function automatic time_t sat_add(time_t a, dur_t b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + (TIME_WIDTH+1)'(b);
    return s[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : s[TIME_WIDTH-1:0];
  endfunction

  // restoring remainder, four compare and subtract steps
  function automatic cursor_t mod_small(cursor_t a, count_t n);
    logic [8:0] r;
    logic [8:0] d;
    r = 9'(a);
    for (int k = CURSOR_W - 1; k >= 0; k--) begin
      d = 9'(n) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[CURSOR_W-1:0];
  endfunction

endpackage

// ===== design/rss_lane.sv =====
// one receiver lane: lock tracking, hang window, dwell timer and target cursor
// depends on rss_pkg
module rss_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick,
  input  logic                 enable,
  input  rss_pkg::count_t      count,
  input  rss_pkg::dur_t        dwell,
  input  rss_pkg::dur_t        hang,
  input  logic                 locked,
  input  rss_pkg::time_t       now,
  output rss_pkg::lane_result_t result
);
  import rss_pkg::*;

  logic    was_locked;
  time_t   hang_end;
  time_t   retune_time;
  logic    has_tuned;
  cursor_t target_cursor;

  logic    active;
  count_t  cnt;
  time_t   dwell_sum;
  time_t   hang_sum;
  time_t   hang_eff;
  logic    fire;
  cursor_t idx;
  cursor_t cursor_next;

  always_comb begin
    active    = enable && (count != '0);
    cnt       = (count > COUNT_W'(MAX_TARGETS)) ? COUNT_W'(MAX_TARGETS) : count;
    dwell_sum = sat_add(now, dwell);
    hang_sum  = sat_add(now, hang);
    hang_eff  = was_locked ? hang_sum : hang_end;
    fire      = active && !locked && !(hang_eff > now) &&
                (!has_tuned || (now >= retune_time));
    idx       = mod_small(target_cursor, cnt);
    cursor_next = ((COUNT_W'(idx) + 1'b1) == cnt) ? '0 : idx + 1'b1;
    result.emit = fire;
    result.idx  = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_locked    <= 1'b0;
      hang_end      <= '0;
      retune_time   <= '0;
      has_tuned     <= 1'b0;
      target_cursor <= '0;
    end else if (tick && active) begin
      if (locked) begin
        was_locked  <= 1'b1;
        hang_end    <= '0;
        retune_time <= dwell_sum;
      end else begin
        if (was_locked) begin
          was_locked <= 1'b0;
          hang_end   <= hang_sum;
        end
        if (fire) begin
          target_cursor <= cursor_next;
          retune_time   <= dwell_sum;
          has_tuned     <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/rss_merge.sv =====
// merging stage: captures the lane results of a tick and sends them out one word
// at a time in receiver order through an output register; depends on rss_pkg
module rss_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick,
  input  rss_pkg::lane_result_t results [rss_pkg::NUM_RECEIVERS],
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           tune_receiver,
  output logic [3:0]           tune_target,
  output logic                 last_of_tick
);
  import rss_pkg::*;

  logic [NUM_RECEIVERS-1:0] pending;
  logic [NUM_RECEIVERS-1:0] pending_next;
  cursor_t                  idx_hold [NUM_RECEIVERS];
  logic                     load;
  logic [1:0]               sel;
  logic                     found;

  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_RECEIVERS; i++) begin
      if (pending[i] && !found) begin
        sel   = 2'(i);
        found = 1'b1;
      end
    end
    load = found && (!out_valid || out_ready);
    pending_next = pending;
    if (load) begin
      pending_next[sel] = 1'b0;
    end
  end

  assign busy = |pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (tick) begin
        for (int i = 0; i < NUM_RECEIVERS; i++) begin
          pending[i] <= results[i].emit;
        end
      end else begin
        pending <= pending_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      for (int i = 0; i < NUM_RECEIVERS; i++) begin
        idx_hold[i] <= results[i].idx;
      end
    end
    if (load) begin
      tune_receiver <= sel;
      tune_target   <= idx_hold[sel];
      last_of_tick  <= (pending_next == '0);
    end
  end

endmodule

// ===== design/receiver_scan_scheduler_core.sv =====
// receiver scan scheduler top level: config registers, per-receiver lanes and merger
// depends on rss_pkg, rss_lane and rss_merge
//
// one input word is one scheduler tick: now_time and one lock bit per receiver,
// taken on in_valid and in_ready. every receiver lane evaluates the tick in
// parallel in the accepting cycle and updates its own timing state. the merger
// then sends the resulting tune commands one word per cycle when not stalled, lowest receiver
// first, on out_valid and out_ready; last_of_tick marks the final word of a tick.
// a tick that causes no command produces no output word.
// an accepted tick is first registered in the merger's pending flags, and its first
// command then goes into the output register. a tick causes 0 to 4 commands, which
// the merger drains one per cycle while the output is not stalled; in_ready is low
// while commands of the previous tick are still queued in the merger.
// an output stall holds the output register and the queue, and so holds in_ready low while commands are queued.
// config writes on cfg_valid and cfg_ready (always ready), index selects
// enable_mask, target_counts, dwell_times or hang_times.
// synchronous reset clears config, lane state, the merger queue and out_valid, not the output data fields.
module receiver_scan_scheduler_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                now_time,
  input  logic [3:0]                 lock_bits,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 tune_receiver,
  output logic [3:0]                 tune_target,
  output logic                       last_of_tick,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rss_pkg::*;

  logic [3:0]  enable_mask;
  logic [19:0] target_counts;
  logic [63:0] dwell_times;
  logic [63:0] hang_times;

  logic         tick;
  logic         busy;
  time_t        now;
  lane_result_t results [NUM_RECEIVERS];

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign tick      = in_valid && in_ready;
  assign now       = TIME_WIDTH'(now_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask   <= '0;
      target_counts <= '0;
      dwell_times   <= '0;
      hang_times    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE_MASK:   enable_mask   <= cfg_data[3:0];
        REG_TARGET_COUNTS: target_counts <= cfg_data[19:0];
        REG_DWELL_TIMES:   dwell_times   <= cfg_data;
        REG_HANG_TIMES:    hang_times    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < NUM_RECEIVERS; i++) begin : g_lane
    rss_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .tick   (tick),
      .enable (enable_mask[i]),
      .count  (target_counts[COUNT_W*i +: COUNT_W]),
      .dwell  (dwell_times[DUR_W*i +: DUR_W]),
      .hang   (hang_times[DUR_W*i +: DUR_W]),
      .locked (lock_bits[i]),
      .now    (now),
      .result (results[i])
    );
  end

  rss_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .results       (results),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tune_receiver (tune_receiver),
    .tune_target   (tune_target),
    .last_of_tick  (last_of_tick)
  );

endmodule

// ===== tb/receiver_scan_scheduler_core_tb.sv =====
// self-checking testbench for receiver_scan_scheduler_core: directed and random scheduler ticks
// with register writes between phases, random stalls on both sides and one long output hold-off
// depends on rss_pkg and the receiver_scan_scheduler_core rtl
module receiver_scan_scheduler_core_tb;
  import rss_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [1:0] rx;
    logic [3:0] tgt;
    logic       last;
  } tune_cmd_t;

  class tune_tracker;
    logic [3:0]  en_mask;
    logic [19:0] tgt_counts;
    logic [63:0] dwell_regs;
    logic [63:0] hang_regs;
    logic        lock_seen  [NUM_RECEIVERS];
    logic [31:0] hang_until [NUM_RECEIVERS];
    logic [31:0] retune_at  [NUM_RECEIVERS];
    logic        tuned_once [NUM_RECEIVERS];
    logic [3:0]  next_pick  [NUM_RECEIVERS];
    tune_cmd_t   due_tunes[$];
    int mismatches;
    int ticks_noted;
    int words_checked;
    int writes_seen;

    function new();
      en_mask = '0;
      tgt_counts = '0;
      dwell_regs = '0;
      hang_regs = '0;
      for (int i = 0; i < NUM_RECEIVERS; i++) begin
        lock_seen[i] = 1'b0;
        hang_until[i] = '0;
        retune_at[i] = '0;
        tuned_once[i] = 1'b0;
        next_pick[i] = '0;
      end
      mismatches = 0;
      ticks_noted = 0;
      words_checked = 0;
      writes_seen = 0;
    endfunction

    function int pending();
      return due_tunes.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] data);
      writes_seen++;
      case (idx)
        REG_ENABLE_MASK:   en_mask = data[3:0];
        REG_TARGET_COUNTS: tgt_counts = data[19:0];
        REG_DWELL_TIMES:   dwell_regs = data;
        REG_HANG_TIMES:    hang_regs = data;
        default: ;
      endcase
    endfunction

    function logic [31:0] clamp_sum(logic [31:0] a, logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void take_tick(logic [31:0] now, logic [3:0] locks);
      tune_cmd_t   cmds[$];
      tune_cmd_t   c;
      logic [4:0]  cnt;
      logic [15:0] dw;
      logic [15:0] hg;
      logic [3:0]  pick;
      ticks_noted++;
      for (int i = 0; i < NUM_RECEIVERS; i++) begin
        cnt = tgt_counts[5*i +: 5];
        dw  = dwell_regs[16*i +: 16];
        hg  = hang_regs[16*i +: 16];
        if (!en_mask[i] || cnt == 0) continue;
        if (cnt > MAX_TARGETS) cnt = 5'(MAX_TARGETS);
        if (locks[i]) begin
          lock_seen[i] = 1'b1;
          hang_until[i] = '0;
          retune_at[i] = clamp_sum(now, dw);
          continue;
        end
        if (lock_seen[i]) begin
          lock_seen[i] = 1'b0;
          hang_until[i] = clamp_sum(now, hg);
        end
        if (hang_until[i] > now) continue;
        if (!tuned_once[i] || now >= retune_at[i]) begin
          pick = 4'(int'(next_pick[i]) % int'(cnt));
          c.rx = 2'(i);
          c.tgt = pick;
          c.last = 1'b0;
          cmds.push_back(c);
          next_pick[i] = 4'((int'(pick) + 1) % int'(cnt));
          retune_at[i] = clamp_sum(now, dw);
          tuned_once[i] = 1'b1;
        end
      end
      if (cmds.size() > 0) cmds[cmds.size()-1].last = 1'b1;
      foreach (cmds[k]) due_tunes.push_back(cmds[k]);
    endfunction

    function void match_word(logic [1:0] rx, logic [3:0] tg, logic lst);
      tune_cmd_t w;
      words_checked++;
      if (due_tunes.size() == 0) begin
        flag($sformatf("unexpected word rx %0d target %0d last %0b", rx, tg, lst));
        return;
      end
      w = due_tunes.pop_front();
      if (rx !== w.rx || tg !== w.tgt || lst !== w.last)
        flag($sformatf("word %0d expected rx %0d target %0d last %0b, got rx %0d target %0d last %0b",
                       words_checked, w.rx, w.tgt, w.last, rx, tg, lst));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [31:0]           now_time;
  logic [3:0]            lock_bits;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            tune_receiver;
  logic [3:0]            tune_target;
  logic                  last_of_tick;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tune_tracker sb;
  bit idle_on;
  bit hold_off;
  bit hold_done;
  int cycles;

  receiver_scan_scheduler_core DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .now_time      (now_time),
    .lock_bits     (lock_bits),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tune_receiver (tune_receiver),
    .tune_target   (tune_target),
    .last_of_tick  (last_of_tick),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int idle_gap();
    return idle_on ? $urandom_range(0, 18) : 0;
  endfunction

  // sample every handshake at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_e'(cfg_index), cfg_data);
      if (in_valid && in_ready) sb.take_tick(now_time, lock_bits);
      if (out_valid && out_ready) sb.match_word(tune_receiver, tune_target, last_of_tick);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // output side
  initial begin
    int n;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      n = idle_gap();
      repeat (n) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      while (hold_off) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // long output hold-off while ticks keep arriving
  initial begin
    hold_off = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (sb.ticks_noted < 70) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
    hold_done = 1'b1;
  end

  task automatic send_tick(input logic [31:0] t, input logic [3:0] lk);
    int n;
    n = idle_gap();
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    now_time  <= t;
    lock_bits <= lk;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    logic [63:0] d;
    logic [4:0]  c;
    d = {$urandom, $urandom};
    write_cfg(REG_ENABLE_MASK, d);
    d = {$urandom, $urandom};
    for (int i = 0; i < NUM_RECEIVERS; i++) begin
      case ($urandom_range(0, 7))
        0:       c = 5'd0;
        1:       c = 5'($urandom_range(17, 31));
        default: c = 5'($urandom_range(1, 16));
      endcase
      d[5*i +: 5] = c;
    end
    write_cfg(REG_TARGET_COUNTS, d);
    for (int i = 0; i < NUM_RECEIVERS; i++)
      d[16*i +: 16] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
    write_cfg(REG_DWELL_TIMES, d);
    for (int i = 0; i < NUM_RECEIVERS; i++)
      d[16*i +: 16] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    write_cfg(REG_HANG_TIMES, d);
  endtask

  // mostly monotonic time with sticky lock bits, some noise ticks
  task automatic random_phase(input int items);
    logic [31:0] t;
    logic [3:0]  lk;
    logic [3:0]  flips;
    if ($urandom_range(0, 3) == 0) t = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
    else t = 32'($urandom_range(0, 1 << 24));
    lk = 4'($urandom);
    repeat (items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_tick($urandom, 4'($urandom));
      end else begin
        t = t + 32'($urandom_range(0, 300));
        flips = '0;
        for (int i = 0; i < NUM_RECEIVERS; i++) flips[i] = ($urandom_range(0, 3) == 0);
        lk = lk ^ flips;
        send_tick(t, lk);
      end
    end
  endtask

  initial begin
    int phase;
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    now_time  = '0;
    lock_bits = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ENABLE_MASK;
    cfg_data  = '0;
    idle_on   = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: nothing enabled
    send_tick(32'd100, 4'h0);
    send_tick(32'd200, 4'hF);
    settle();

    write_cfg(REG_ENABLE_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(REG_TARGET_COUNTS, 64'((31 << 15) | (16 << 10) | (1 << 5) | 3));
    write_cfg(REG_DWELL_TIMES, 64'hFFFF_0000_0032_0064);
    write_cfg(REG_HANG_TIMES, 64'hFFFF_0000_0014_0028);
    send_tick(32'd1000, 4'h0);
    send_tick(32'd1000, 4'h0);
    send_tick(32'd1060, 4'h3);
    send_tick(32'd1070, 4'h0);
    send_tick(32'd1120, 4'h0);
    send_tick(32'd1160, 4'h0);
    // saturating sums near the top of the time range
    send_tick(32'hFFFF_FF00, 4'h8);
    send_tick(32'hFFFF_FFFF, 4'h0);
    send_tick(32'hFFFF_FFFF, 4'hF);
    // time going backwards
    send_tick(32'h0000_0010, 4'h0);
    send_tick(32'h0000_0100, 4'h0);
    settle();

    // shrunk lists leave stale cursors, an empty lane and a disabled lane
    write_cfg(REG_ENABLE_MASK, 64'h0000_0000_0000_0007);
    write_cfg(REG_TARGET_COUNTS, 64'((5 << 15) | (3 << 10) | (0 << 5) | 2));
    write_cfg(REG_DWELL_TIMES, 64'h0);
    write_cfg(REG_HANG_TIMES, 64'h0);
    send_tick(32'h200, 4'h0);
    send_tick(32'h200, 4'hF);
    send_tick(32'h201, 4'h0);
    settle();

    write_cfg(REG_ENABLE_MASK, 64'h0000_0000_0000_000F);
    write_cfg(REG_TARGET_COUNTS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(REG_DWELL_TIMES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(REG_HANG_TIMES, 64'hFFFF_FFFF_FFFF_FFFF);
    send_tick(32'h0001_0000, 4'h0);
    send_tick(32'h0002_0000, 4'h5);
    send_tick(32'h0003_0000, 4'h0);
    send_tick(32'h0004_0000, 4'h0);
    settle();

    phase = 0;
    while (phase < 6 || (sb.words_checked < 48 && phase < 12)) begin
      idle_on = (phase % 2 == 0);
      random_config();
      random_phase(35);
      settle();
      phase++;
    end

    while (!hold_done) @(posedge clk);
    settle();
    repeat (10) @(posedge clk);

    $display("covered %0d ticks and %0d tune words over %0d register writes in %0d random phases",
             sb.ticks_noted, sb.words_checked, sb.writes_seen, phase);
    $display("random stalls on both sides and one %0d cycle output hold-off", HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", sb.mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rss_pkg.sv
design/rss_lane.sv
design/rss_merge.sv
design/receiver_scan_scheduler_core.sv
tb/receiver_scan_scheduler_core_tb.sv
